// File: src/vtp_pkg.sv
package vtp_pkg;

    localparam int MAX_PARAMS = 16;
    localparam int PIDX_W     = $clog2(MAX_PARAMS);
    localparam int PCNT_W     = $clog2(MAX_PARAMS + 1);

    localparam logic [15:0] CH_BEL = 16'h0007;
    localparam logic [15:0] CH_ESC = 16'h001B;
    localparam logic [15:0] CH_ST  = 16'h009C;

    localparam logic [5:0] K_TEXT      = 6'd0;
    localparam logic [5:0] K_BELL      = 6'd1;
    localparam logic [5:0] K_UP        = 6'd2;
    localparam logic [5:0] K_DOWN      = 6'd3;
    localparam logic [5:0] K_FWD       = 6'd4;
    localparam logic [5:0] K_BACK      = 6'd5;
    localparam logic [5:0] K_NEXTLN    = 6'd6;
    localparam logic [5:0] K_PREVLN    = 6'd7;
    localparam logic [5:0] K_COLUMN    = 6'd8;
    localparam logic [5:0] K_POS       = 6'd9;
    localparam logic [5:0] K_TAB       = 6'd10;
    localparam logic [5:0] K_SETTAB    = 6'd11;
    localparam logic [5:0] K_SAVE      = 6'd12;
    localparam logic [5:0] K_RESTORE   = 6'd13;
    localparam logic [5:0] K_CLR       = 6'd14;
    localparam logic [5:0] K_CLR_FROM  = 6'd15;
    localparam logic [5:0] K_CLR_TO    = 6'd16;
    localparam logic [5:0] K_CLRLN     = 6'd17;
    localparam logic [5:0] K_CLRLN_FROM = 6'd18;
    localparam logic [5:0] K_CLRLN_TO  = 6'd19;
    localparam logic [5:0] K_INSLN     = 6'd20;
    localparam logic [5:0] K_DELLN     = 6'd21;
    localparam logic [5:0] K_INSCH     = 6'd22;
    localparam logic [5:0] K_DELCH     = 6'd23;
    localparam logic [5:0] K_ERASECH   = 6'd24;
    localparam logic [5:0] K_SCRUP     = 6'd25;
    localparam logic [5:0] K_SCRDN     = 6'd26;
    localparam logic [5:0] K_REGION    = 6'd27;
    localparam logic [5:0] K_MODE      = 6'd28;
    localparam logic [5:0] K_PMODE     = 6'd29;
    localparam logic [5:0] K_ALTSCR    = 6'd30;
    localparam logic [5:0] K_SETATTR   = 6'd31;
    localparam logic [5:0] K_RSTATTR   = 6'd32;
    localparam logic [5:0] K_DSR       = 6'd33;
    localparam logic [5:0] K_CPR       = 6'd34;

    localparam logic [1:0] REG_DEFAULT = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_GFX     = 2'd2;

    typedef enum logic [2:0] {
        PM_NORMAL = 3'd0,
        PM_ESCAPE = 3'd1,
        PM_CSI    = 3'd2,
        PM_OSC    = 3'd3,
        PM_DCS    = 3'd4,
        PM_OTHER  = 3'd5
    } pmode_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SEQ   = 5'b00010,
        ST_FINAL = 5'b00100,
        ST_RD    = 5'b01000,
        ST_WALK  = 5'b10000
    } state_t;

    typedef struct packed {
        logic [15:0] default_param;
        logic [7:0]  screen_rows;
        logic        gfx_on;
    } cfg_t;

    typedef struct packed {
        logic [4:0] fg;
        logic [4:0] bg;
        logic [6:0] attrs;
    } color_t;

    localparam logic [15:0] GFX_TABLE [32] = '{
        16'h00A0, 16'h25C6, 16'h2591, 16'h2409, 16'h240C, 16'h240D, 16'h240A, 16'h00B0,
        16'h00B1, 16'h2424, 16'h240B, 16'h2518, 16'h2510, 16'h250C, 16'h2514, 16'h253C,
        16'h23BA, 16'h23BB, 16'h2500, 16'h23BC, 16'h23BD, 16'h251C, 16'h2524, 16'h2534,
        16'h252C, 16'h2502, 16'h2264, 16'h2265, 16'h03C0, 16'h2260, 16'h00A3, 16'h00B7
    };

    function automatic color_t apply_sgr(input logic [15:0] p, input color_t c);
        color_t r;
        r = c;
        unique case (p) inside
            16'd0: r = '0;
            16'd1: r.attrs = c.attrs | 7'h01;
            16'd2: r.attrs = c.attrs | 7'h02;
            16'd3: r.attrs = c.attrs | 7'h04;
            16'd4: r.attrs = c.attrs | 7'h08;
            16'd5: r.attrs = c.attrs | 7'h10;
            16'd7: r.attrs = c.attrs | 7'h20;
            16'd9: r.attrs = c.attrs | 7'h40;
            16'd22: r.attrs = c.attrs & ~7'h03;
            16'd23: r.attrs = c.attrs & ~7'h04;
            16'd24: r.attrs = c.attrs & ~7'h08;
            16'd25: r.attrs = c.attrs & ~7'h10;
            16'd27: r.attrs = c.attrs & ~7'h20;
            16'd29: r.attrs = c.attrs & ~7'h40;
            16'd39: r.fg = 5'd0;
            16'd49: r.bg = 5'd0;
            [16'd30:16'd37]: r.fg = 5'(p - 16'd29);
            [16'd40:16'd47]: r.bg = 5'(p - 16'd39);
            [16'd90:16'd97]: r.fg = 5'(p - 16'd81);
            [16'd100:16'd107]: r.bg = 5'(p - 16'd91);
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// File: src/vt100_escape_sequence_parser_top.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_code_unit
// m_        out  m_valid/m_ready    m_kind m_arg_a m_arg_b m_fg_color m_bg_color
//                                   m_attributes m_last
// apb       in   psel/penable       paddr pwdata pwrite -> prdata
// Plain units and most CSI bytes are handled in idle; multi-command controls emit in order.
// A CSI final byte passes through the final state; SGR and mode lists then walk each stored
// parameter (alternate-screen entries add a command): one parameter memory read, then one use.
// Synchronous active-low reset; no clearing pass, parameter memory needs none.
// One request at a time; a result stalled at m_ stalls the walk and s_ready.
module vt100_escape_sequence_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_kind,
    output logic [15:0] m_arg_a,
    output logic [15:0] m_arg_b,
    output logic [4:0]  m_fg_color,
    output logic [4:0]  m_bg_color,
    output logic [6:0]  m_attributes,
    output logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vtp_pkg::*;

    cfg_t cfg;

    vtp_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [15:0] mem [MAX_PARAMS];
    logic [15:0] rdata_reg;
    logic              mem_we;
    logic [PIDX_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;

    state_t state_reg, state_next;
    pmode_t pmode_reg, pmode_next;
    logic marker_reg, marker_next;
    logic [PCNT_W-1:0] count_reg, count_next;
    logic [16:0] acc_reg, acc_next;
    logic seen_reg, seen_next, inval_reg, inval_next, text_reg, text_next;
    logic [15:0] p0_reg, p0_next, p1_reg, p1_next;
    color_t col_reg, col_next;
    logic [6:0] final_reg, final_next;
    logic step_reg, step_next, half_reg, half_next;
    logic [PIDX_W-1:0] idx_reg, idx_next;

    logic m_valid_reg;
    logic [5:0] kind_reg;
    logic [15:0] a_reg, b_reg;
    color_t mcol_reg;
    logic last_reg;

    logic emit_v, emit_last;
    logic [5:0] emit_kind;
    logic [15:0] emit_a, emit_b;

    logic can_emit, accept, do_finish, fin_ok, clear_seq;
    logic [15:0] c;
    logic [20:0] acc_mul;
    logic [15:0] count_arg, nth1, bottom, p0, p;
    logic last_idx, set_bit;

    assign can_emit = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && can_emit;
    assign accept   = s_valid && s_ready;
    assign c        = s_code_unit;
    assign acc_mul  = {1'b0, acc_reg, 3'd0} + {3'd0, acc_reg, 1'b0} + {17'd0, c[3:0]};
    assign fin_ok   = seen_reg && !inval_reg && !acc_reg[16];
    assign p0       = (count_reg != '0) ? p0_reg : 16'd0;
    assign count_arg = (count_reg == '0 || p0_reg == 16'd0) ? 16'd1 : p0_reg;
    assign nth1     = (count_reg <= PCNT_W'(1) || p1_reg == 16'd0) ? 16'd1 : p1_reg;
    assign bottom   = (count_reg > PCNT_W'(1)) ? nth1 :
                      (cfg.screen_rows != 8'd0) ? {8'd0, cfg.screen_rows} : 16'd1;
    assign p        = rdata_reg;
    assign last_idx = ({1'b0, idx_reg} == count_reg - PCNT_W'(1));
    assign set_bit  = (final_reg == 7'h68);
    assign mem_re   = (state_reg == ST_RD);
    assign mem_wdata = fin_ok ? acc_reg[15:0] : cfg.default_param;
    assign mem_waddr = count_reg[PIDX_W-1:0];

    always_comb begin
        state_next = state_reg;
        pmode_next = pmode_reg;
        marker_next = marker_reg;
        count_next = count_reg;
        acc_next = acc_reg;
        seen_next = seen_reg;
        inval_next = inval_reg;
        text_next = text_reg;
        p0_next = p0_reg;
        p1_next = p1_reg;
        col_next = col_reg;
        final_next = final_reg;
        step_next = step_reg;
        half_next = half_reg;
        idx_next = idx_reg;
        emit_v = 1'b0;
        emit_last = 1'b1;
        emit_kind = K_TEXT;
        emit_a = 16'd0;
        emit_b = 16'd0;
        do_finish = 1'b0;
        clear_seq = 1'b0;
        mem_we = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (pmode_reg)
                        PM_NORMAL: begin
                            if (c == CH_ESC) begin
                                pmode_next = PM_ESCAPE;
                                clear_seq = 1'b1;
                            end else if (c < 16'd32) begin
                                case (c[4:0])
                                    5'h07: begin emit_v = 1'b1; emit_kind = K_BELL; end
                                    5'h08: begin
                                        emit_v = 1'b1; emit_kind = K_BACK; emit_a = 16'd1;
                                    end
                                    5'h09: begin
                                        emit_v = 1'b1; emit_kind = K_TAB; emit_a = 16'd1;
                                    end
                                    5'h0A, 5'h0B: begin
                                        emit_v = 1'b1; emit_kind = K_DOWN; emit_a = 16'd1;
                                    end
                                    5'h0C: begin
                                        emit_v = 1'b1; emit_kind = K_CLR; emit_last = 1'b0;
                                        step_next = 1'b1;
                                        state_next = ST_SEQ;
                                    end
                                    5'h0D: begin emit_v = 1'b1; emit_kind = K_COLUMN; end
                                    default: emit_v = 1'b0;
                                endcase
                            end else begin
                                emit_v = 1'b1;
                                emit_kind = K_TEXT;
                                emit_a = (cfg.gfx_on && c >= 16'h5F && c <= 16'h7E) ?
                                         GFX_TABLE[5'(c - 16'h5F)] : c;
                            end
                        end
                        PM_ESCAPE: begin
                            pmode_next = PM_NORMAL;
                            clear_seq = 1'b1;
                            case (c)
                                16'h5B: begin pmode_next = PM_CSI; clear_seq = 1'b0; end
                                16'h5D: begin pmode_next = PM_OSC; clear_seq = 1'b0; end
                                16'h50: begin pmode_next = PM_DCS; clear_seq = 1'b0; end
                                16'h58, 16'h5E, 16'h5F: begin
                                    pmode_next = PM_OTHER; clear_seq = 1'b0;
                                end
                                16'h44: begin emit_v = 1'b1; emit_kind = K_DOWN; emit_a = 16'd1; end
                                16'h45: begin
                                    emit_v = 1'b1; emit_kind = K_NEXTLN; emit_a = 16'd1;
                                end
                                16'h48: begin emit_v = 1'b1; emit_kind = K_SETTAB; end
                                16'h4D: begin emit_v = 1'b1; emit_kind = K_UP; emit_a = 16'd1; end
                                16'h37: begin emit_v = 1'b1; emit_kind = K_SAVE; end
                                16'h38: begin emit_v = 1'b1; emit_kind = K_RESTORE; end
                                16'h3D: begin
                                    emit_v = 1'b1; emit_kind = K_PMODE;
                                    emit_a = 16'd1; emit_b = 16'd1;
                                end
                                16'h3E: begin
                                    emit_v = 1'b1; emit_kind = K_PMODE; emit_a = 16'd1;
                                end
                                16'h63: begin
                                    emit_v = 1'b1; emit_kind = K_RSTATTR; emit_last = 1'b0;
                                    step_next = 1'b0;
                                    state_next = ST_SEQ;
                                end
                                default: emit_v = 1'b0;
                            endcase
                        end
                        PM_CSI: begin
                            if (c >= 16'h30 && c <= 16'h39) begin
                                acc_next = (acc_mul > 21'h0FFFF) ? 17'h10000 : acc_mul[16:0];
                                seen_next = 1'b1;
                                text_next = 1'b1;
                            end else if (c == 16'h3B) begin
                                text_next = 1'b1;
                                do_finish = 1'b1;
                            end else if (c == 16'h3F) begin
                                if (!marker_reg && !text_reg) begin
                                    marker_next = 1'b1;
                                end else begin
                                    seen_next = 1'b1; inval_next = 1'b1; text_next = 1'b1;
                                end
                            end else if (c >= 16'h20 && c <= 16'h2F) begin
                                text_next = text_reg;
                            end else if (c >= 16'h40 && c <= 16'h7E) begin
                                do_finish = text_reg;
                                final_next = c[6:0];
                                pmode_next = PM_NORMAL;
                                state_next = ST_FINAL;
                            end else begin
                                pmode_next = PM_NORMAL;
                                clear_seq = 1'b1;
                            end
                        end
                        PM_OSC: begin
                            if (c == CH_BEL || c == CH_ESC) begin
                                pmode_next = PM_NORMAL; clear_seq = 1'b1;
                            end
                        end
                        PM_DCS: begin
                            if (c == CH_ESC || c == CH_ST) begin
                                pmode_next = PM_NORMAL; clear_seq = 1'b1;
                            end
                        end
                        default: begin
                            if (c == CH_ESC || c == CH_BEL || c == CH_ST) begin
                                pmode_next = PM_NORMAL; clear_seq = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_SEQ: begin
                if (can_emit) begin
                    emit_v = 1'b1;
                    if (!step_reg) begin
                        emit_kind = K_CLR; emit_last = 1'b0; step_next = 1'b1;
                    end else begin
                        emit_kind = K_POS; state_next = ST_IDLE;
                    end
                end
            end
            ST_FINAL: begin
                if (can_emit) begin
                    state_next = ST_IDLE;
                    clear_seq = 1'b1;
                    case (final_reg)
                        7'h41: begin emit_v = 1'b1; emit_kind = K_UP; emit_a = count_arg; end
                        7'h42: begin emit_v = 1'b1; emit_kind = K_DOWN; emit_a = count_arg; end
                        7'h43: begin emit_v = 1'b1; emit_kind = K_FWD; emit_a = count_arg; end
                        7'h44: begin emit_v = 1'b1; emit_kind = K_BACK; emit_a = count_arg; end
                        7'h45: begin emit_v = 1'b1; emit_kind = K_NEXTLN; emit_a = count_arg; end
                        7'h46: begin emit_v = 1'b1; emit_kind = K_PREVLN; emit_a = count_arg; end
                        7'h47: begin
                            emit_v = 1'b1; emit_kind = K_COLUMN; emit_a = count_arg - 16'd1;
                        end
                        7'h48, 7'h66: begin
                            emit_v = 1'b1; emit_kind = K_POS;
                            emit_a = count_arg - 16'd1; emit_b = nth1 - 16'd1;
                        end
                        7'h4A: begin
                            emit_v = (p0 <= 16'd3);
                            emit_kind = (p0 == 16'd0) ? K_CLR_FROM :
                                        (p0 == 16'd1) ? K_CLR_TO : K_CLR;
                        end
                        7'h4B: begin
                            emit_v = (p0 <= 16'd2);
                            emit_kind = (p0 == 16'd0) ? K_CLRLN_FROM :
                                        (p0 == 16'd1) ? K_CLRLN_TO : K_CLRLN;
                        end
                        7'h4C: begin emit_v = 1'b1; emit_kind = K_INSLN; emit_a = count_arg; end
                        7'h4D: begin emit_v = 1'b1; emit_kind = K_DELLN; emit_a = count_arg; end
                        7'h50: begin emit_v = 1'b1; emit_kind = K_DELCH; emit_a = count_arg; end
                        7'h53: begin emit_v = 1'b1; emit_kind = K_SCRUP; emit_a = count_arg; end
                        7'h54: begin emit_v = 1'b1; emit_kind = K_SCRDN; emit_a = count_arg; end
                        7'h58: begin emit_v = 1'b1; emit_kind = K_ERASECH; emit_a = count_arg; end
                        7'h40: begin emit_v = 1'b1; emit_kind = K_INSCH; emit_a = count_arg; end
                        7'h72: begin
                            emit_v = 1'b1; emit_kind = K_REGION;
                            emit_a = count_arg - 16'd1; emit_b = bottom - 16'd1;
                        end
                        7'h73: begin emit_v = 1'b1; emit_kind = K_SAVE; end
                        7'h75: begin emit_v = 1'b1; emit_kind = K_RESTORE; end
                        7'h6E: begin
                            emit_v = (p0 == 16'd5) || (p0 == 16'd6);
                            emit_kind = (p0 == 16'd5) ? K_DSR : K_CPR;
                        end
                        7'h6D: begin
                            if (count_reg == '0) begin
                                col_next = '0;
                                emit_v = 1'b1; emit_kind = K_SETATTR;
                            end else begin
                                idx_next = '0; state_next = ST_RD; clear_seq = 1'b0;
                            end
                        end
                        7'h68, 7'h6C: begin
                            if (count_reg != '0) begin
                                idx_next = '0; half_next = 1'b0;
                                state_next = ST_RD; clear_seq = 1'b0;
                            end
                        end
                        default: emit_v = 1'b0;
                    endcase
                end
            end
            ST_RD: begin
                state_next = ST_WALK;
            end
            default: begin
                if (can_emit) begin
                    if (final_reg == 7'h6D) begin
                        col_next = apply_sgr(p, col_reg);
                        if (last_idx) begin
                            emit_v = 1'b1; emit_kind = K_SETATTR;
                            state_next = ST_IDLE; clear_seq = 1'b1;
                        end else begin
                            idx_next = idx_reg + PIDX_W'(1); state_next = ST_RD;
                        end
                    end else if (marker_reg && !half_reg &&
                                 (p == 16'd1049 || p == 16'd47)) begin
                        emit_v = 1'b1; emit_kind = K_ALTSCR;
                        emit_b = {15'd0, set_bit}; emit_last = 1'b0;
                        half_next = 1'b1;
                    end else begin
                        emit_v = 1'b1;
                        emit_kind = marker_reg ? K_PMODE : K_MODE;
                        emit_a = p; emit_b = {15'd0, set_bit};
                        emit_last = last_idx;
                        half_next = 1'b0;
                        if (last_idx) begin
                            state_next = ST_IDLE; clear_seq = 1'b1;
                        end else begin
                            idx_next = idx_reg + PIDX_W'(1); state_next = ST_RD;
                        end
                    end
                end
            end
        endcase

        if (do_finish) begin
            if (count_reg < PCNT_W'(MAX_PARAMS)) begin
                mem_we = 1'b1;
                count_next = count_reg + PCNT_W'(1);
                if (count_reg == '0) p0_next = mem_wdata;
                if (count_reg == PCNT_W'(1)) p1_next = mem_wdata;
            end
            acc_next = '0;
            seen_next = 1'b0;
            inval_next = 1'b0;
        end

        if (clear_seq) begin
            marker_next = 1'b0;
            count_next = '0;
            acc_next = '0;
            seen_next = 1'b0;
            inval_next = 1'b0;
            text_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pmode_reg <= PM_NORMAL;
            marker_reg <= 1'b0;
            count_reg <= '0;
            acc_reg <= '0;
            seen_reg <= 1'b0;
            inval_reg <= 1'b0;
            text_reg <= 1'b0;
            col_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pmode_reg <= pmode_next;
            marker_reg <= marker_next;
            count_reg <= count_next;
            acc_reg <= acc_next;
            seen_reg <= seen_next;
            inval_reg <= inval_next;
            text_reg <= text_next;
            col_reg <= col_next;
            m_valid_reg <= emit_v || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
        final_reg <= final_next;
        step_reg <= step_next;
        half_reg <= half_next;
        idx_reg <= idx_next;
        if (emit_v) begin
            kind_reg <= emit_kind;
            a_reg <= emit_a;
            b_reg <= emit_b;
            mcol_reg <= col_next;
            last_reg <= emit_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = kind_reg;
    assign m_arg_a      = a_reg;
    assign m_arg_b      = b_reg;
    assign m_fg_color   = mcol_reg.fg;
    assign m_bg_color   = mcol_reg.bg;
    assign m_attributes = mcol_reg.attrs;
    assign m_last       = last_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PCNT_W'(MAX_PARAMS))
        else $error("parameter count overflow");
    a_walk_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK || state_reg == ST_RD) |-> ({1'b0, idx_reg} < count_reg))
        else $error("walk index beyond stored parameters");
    a_final_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && pmode_reg == PM_CSI && c >= 16'h40 && c <= 16'h7E) |=>
        (state_reg == ST_FINAL))
        else $error("final byte did not start command");
    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("request taken while busy");
    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_v |-> can_emit)
        else $error("result overwrote pending result");
`endif

endmodule

// File: src/vtp_cfg_regs.sv
module vtp_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output vtp_pkg::cfg_t     cfg
);
    import vtp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_DEFAULT: cfg_next.default_param = pwdata[15:0];
                REG_ROWS:    cfg_next.screen_rows   = pwdata[7:0];
                REG_GFX:     cfg_next.gfx_on        = pwdata[0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DEFAULT: prdata = {16'd0, cfg_reg.default_param};
            REG_ROWS:    prdata = {24'd0, cfg_reg.screen_rows};
            REG_GFX:     prdata = {31'd0, cfg_reg.gfx_on};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.default_param <= 16'd0;
            cfg_reg.screen_rows   <= 8'd24;
            cfg_reg.gfx_on        <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: tb/sv/vt100_escape_sequence_parser_top_tb.sv
`timescale 1ns / 1ps

module vt100_escape_sequence_parser_top_tb;
    import vtp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic [4:0]  fg;
        logic [4:0]  bg;
        logic [6:0]  attrs;
        logic        last;
    } cmd_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_code_unit;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_kind;
    logic [15:0] m_arg_a;
    logic [15:0] m_arg_b;
    logic [4:0]  m_fg_color;
    logic [4:0]  m_bg_color;
    logic [6:0]  m_attributes;
    logic        m_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vt100_escape_sequence_parser_top i_dut (.*);

    // predictor state
    logic [15:0] cfg_default;
    logic [7:0]  cfg_rows;
    logic        cfg_gfx;
    pmode_t      pr_mode;
    logic        pr_private;
    logic [15:0] pr_params [MAX_PARAMS];
    int          pr_count;
    int unsigned pr_acc;
    logic        pr_seen, pr_invalid, pr_text;
    logic [4:0]  pr_fg, pr_bg;
    logic [6:0]  pr_attrs;

    cmd_t        expected_cmds[$];
    cmd_t        unit_cmds[$];
    logic [15:0] pending_units[$];
    int          mismatches;
    int          units_sent;
    int          idle_cycles;

    always #2 aclk = ~aclk;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic void push_cmd(input logic [5:0] k, input int a, input int b);
        cmd_t c;
        if (unit_cmds.size() < 32) begin
            c.kind = k;
            c.arg_a = a[15:0];
            c.arg_b = b[15:0];
            c.fg = pr_fg;
            c.bg = pr_bg;
            c.attrs = pr_attrs;
            c.last = 1'b0;
            unit_cmds.push_back(c);
        end
    endfunction

    function automatic void clear_seq();
        pr_private = 0;
        pr_count = 0;
        pr_acc = 0;
        pr_seen = 0;
        pr_invalid = 0;
        pr_text = 0;
    endfunction

    function automatic void close_part();
        if (pr_count < MAX_PARAMS) begin
            pr_params[pr_count] = (pr_seen && !pr_invalid && pr_acc <= 65535) ?
                                  pr_acc[15:0] : cfg_default;
            pr_count++;
        end
        pr_acc = 0;
        pr_seen = 0;
        pr_invalid = 0;
    endfunction

    function automatic int nth_count(input int i);
        if (pr_count <= i || pr_params[i] == 0) return 1;
        return pr_params[i];
    endfunction

    function automatic void sgr_update(input logic [15:0] p);
        case (p)
            0: begin pr_fg = 0; pr_bg = 0; pr_attrs = 0; end
            1: pr_attrs |= 7'h01;
            2: pr_attrs |= 7'h02;
            3: pr_attrs |= 7'h04;
            4: pr_attrs |= 7'h08;
            5: pr_attrs |= 7'h10;
            7: pr_attrs |= 7'h20;
            9: pr_attrs |= 7'h40;
            22: pr_attrs &= ~7'h03;
            23: pr_attrs &= ~7'h04;
            24: pr_attrs &= ~7'h08;
            25: pr_attrs &= ~7'h10;
            27: pr_attrs &= ~7'h20;
            29: pr_attrs &= ~7'h40;
            39: pr_fg = 0;
            49: pr_bg = 0;
            default: begin
                if (p >= 30 && p <= 37) pr_fg = 5'(p - 29);
                else if (p >= 40 && p <= 47) pr_bg = 5'(p - 39);
                else if (p >= 90 && p <= 97) pr_fg = 5'(p - 81);
                else if (p >= 100 && p <= 107) pr_bg = 5'(p - 91);
            end
        endcase
    endfunction

    function automatic void csi_final(input logic [15:0] f);
        int p0;
        int bottom;
        p0 = pr_count ? pr_params[0] : 0;
        case (f)
            "A": push_cmd(K_UP, nth_count(0), 0);
            "B": push_cmd(K_DOWN, nth_count(0), 0);
            "C": push_cmd(K_FWD, nth_count(0), 0);
            "D": push_cmd(K_BACK, nth_count(0), 0);
            "E": push_cmd(K_NEXTLN, nth_count(0), 0);
            "F": push_cmd(K_PREVLN, nth_count(0), 0);
            "G": push_cmd(K_COLUMN, nth_count(0) - 1, 0);
            "H", "f": push_cmd(K_POS, nth_count(0) - 1, nth_count(1) - 1);
            "J": begin
                if (p0 == 0) push_cmd(K_CLR_FROM, 0, 0);
                else if (p0 == 1) push_cmd(K_CLR_TO, 0, 0);
                else if (p0 == 2 || p0 == 3) push_cmd(K_CLR, 0, 0);
            end
            "K": begin
                if (p0 == 0) push_cmd(K_CLRLN_FROM, 0, 0);
                else if (p0 == 1) push_cmd(K_CLRLN_TO, 0, 0);
                else if (p0 == 2) push_cmd(K_CLRLN, 0, 0);
            end
            "L": push_cmd(K_INSLN, nth_count(0), 0);
            "M": push_cmd(K_DELLN, nth_count(0), 0);
            "P": push_cmd(K_DELCH, nth_count(0), 0);
            "S": push_cmd(K_SCRUP, nth_count(0), 0);
            "T": push_cmd(K_SCRDN, nth_count(0), 0);
            "X": push_cmd(K_ERASECH, nth_count(0), 0);
            "@": push_cmd(K_INSCH, nth_count(0), 0);
            "m": begin
                if (pr_count == 0) sgr_update(0);
                for (int i = 0; i < pr_count; i++) sgr_update(pr_params[i]);
                push_cmd(K_SETATTR, 0, 0);
            end
            "r": begin
                if (pr_count > 1) bottom = nth_count(1);
                else bottom = cfg_rows ? cfg_rows : 1;
                push_cmd(K_REGION, nth_count(0) - 1, bottom - 1);
            end
            "s": push_cmd(K_SAVE, 0, 0);
            "u": push_cmd(K_RESTORE, 0, 0);
            "n": begin
                if (p0 == 5) push_cmd(K_DSR, 0, 0);
                else if (p0 == 6) push_cmd(K_CPR, 0, 0);
            end
            "h", "l": begin
                for (int i = 0; i < pr_count; i++) begin
                    if (pr_private) begin
                        if (pr_params[i] == 1049 || pr_params[i] == 47)
                            push_cmd(K_ALTSCR, 0, f == "h");
                        push_cmd(K_PMODE, pr_params[i], f == "h");
                    end else begin
                        push_cmd(K_MODE, pr_params[i], f == "h");
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_unit(input logic [15:0] c);
        unit_cmds.delete();
        case (pr_mode)
            PM_NORMAL: begin
                if (c == CH_ESC) begin
                    pr_mode = PM_ESCAPE;
                    clear_seq();
                end else if (c < 32) begin
                    case (c)
                        16'h07: push_cmd(K_BELL, 0, 0);
                        16'h08: push_cmd(K_BACK, 1, 0);
                        16'h09: push_cmd(K_TAB, 1, 0);
                        16'h0A, 16'h0B: push_cmd(K_DOWN, 1, 0);
                        16'h0C: begin push_cmd(K_CLR, 0, 0); push_cmd(K_POS, 0, 0); end
                        16'h0D: push_cmd(K_COLUMN, 0, 0);
                        default: ;
                    endcase
                end else if (cfg_gfx && c >= 16'h5F && c <= 16'h7E) begin
                    push_cmd(K_TEXT, GFX_TABLE[c - 16'h5F], 0);
                end else begin
                    push_cmd(K_TEXT, c, 0);
                end
            end
            PM_ESCAPE: begin
                pr_mode = PM_NORMAL;
                case (c)
                    "[": pr_mode = PM_CSI;
                    "]": pr_mode = PM_OSC;
                    "P": pr_mode = PM_DCS;
                    "X", "^", "_": pr_mode = PM_OTHER;
                    "D": push_cmd(K_DOWN, 1, 0);
                    "E": push_cmd(K_NEXTLN, 1, 0);
                    "H": push_cmd(K_SETTAB, 0, 0);
                    "M": push_cmd(K_UP, 1, 0);
                    "7": push_cmd(K_SAVE, 0, 0);
                    "8": push_cmd(K_RESTORE, 0, 0);
                    "=": push_cmd(K_PMODE, 1, 1);
                    ">": push_cmd(K_PMODE, 1, 0);
                    "c": begin
                        push_cmd(K_RSTATTR, 0, 0);
                        push_cmd(K_CLR, 0, 0);
                        push_cmd(K_POS, 0, 0);
                    end
                    default: ;
                endcase
                if (pr_mode == PM_NORMAL) clear_seq();
            end
            PM_CSI: begin
                if (c >= "0" && c <= "9") begin
                    pr_acc = pr_acc * 10 + (c - "0");
                    if (pr_acc > 65535) pr_acc = 65536;
                    pr_seen = 1;
                    pr_text = 1;
                end else if (c == ";") begin
                    pr_text = 1;
                    close_part();
                end else if (c == "?") begin
                    if (!pr_private && !pr_text) pr_private = 1;
                    else begin pr_seen = 1; pr_invalid = 1; pr_text = 1; end
                end else if (c >= 16'h20 && c <= 16'h2F) begin
                end else if (c >= 16'h40 && c <= 16'h7E) begin
                    if (pr_text) close_part();
                    csi_final(c);
                    pr_mode = PM_NORMAL;
                    clear_seq();
                end else begin
                    pr_mode = PM_NORMAL;
                    clear_seq();
                end
            end
            PM_OSC: if (c == CH_BEL || c == CH_ESC) begin pr_mode = PM_NORMAL; clear_seq(); end
            PM_DCS: if (c == CH_ESC || c == CH_ST) begin pr_mode = PM_NORMAL; clear_seq(); end
            default: begin
                if (c == CH_ESC || c == CH_BEL || c == CH_ST) begin
                    pr_mode = PM_NORMAL;
                    clear_seq();
                end
            end
        endcase
        if (unit_cmds.size() > 0) unit_cmds[unit_cmds.size() - 1].last = 1'b1;
        foreach (unit_cmds[i]) expected_cmds.push_back(unit_cmds[i]);
    endfunction

    // driver: bursts with random gaps
    int gap_left, burst_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_unit(s_code_unit);
                units_sent <= units_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    s_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_units.size() > 0) begin
                    s_valid <= 1'b1;
                    s_code_unit <= pending_units.pop_front();
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor with its own stall pattern
    int stall_phase;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_phase <= 0;
            idle_cycles <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if ((stall_phase / 64) % 3 == 0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 99) < 65);
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_cmds.size() == 0) begin
                    report($sformatf("unexpected command kind %0d", m_kind));
                end else begin
                    cmd_t e;
                    e = expected_cmds.pop_front();
                    if (m_kind !== e.kind)
                        report($sformatf("kind %0d, want %0d", m_kind, e.kind));
                    if (m_arg_a !== e.arg_a)
                        report($sformatf("arg_a %h, want %h", m_arg_a, e.arg_a));
                    if (m_arg_b !== e.arg_b)
                        report($sformatf("arg_b %h, want %h", m_arg_b, e.arg_b));
                    if (m_fg_color !== e.fg)
                        report($sformatf("fg %0d, want %0d", m_fg_color, e.fg));
                    if (m_bg_color !== e.bg)
                        report($sformatf("bg %0d, want %0d", m_bg_color, e.bg));
                    if (m_attributes !== e.attrs)
                        report($sformatf("attrs %h, want %h", m_attributes, e.attrs));
                    if (m_last !== e.last)
                        report($sformatf("last %b, want %b", m_last, e.last));
                end
            end
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DEFAULT: cfg_default = val[15:0];
            REG_ROWS: cfg_rows = val[7:0];
            default: cfg_gfx = val[0];
        endcase
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) pending_units.push_back(16'(s[i]));
    endtask

    task automatic push_num(input int unsigned v);
        push_str($sformatf("%0d", v));
    endtask

    task automatic run_and_drain();
        wait (pending_units.size() == 0);
        @(posedge aclk);
        while (s_valid || expected_cmds.size() > 0) @(posedge aclk);
        // a final byte may still be walking the parameter list
        repeat (80) @(posedge aclk);
    endtask

    // adds random sequences until at least n more code units are queued
    task automatic add_random_units(input int n);
        string finals;
        int pick;
        int np;
        int start;
        finals = "ABCDEFGHJKLMPSTX@mrsunhlf`Zq";
        start = pending_units.size();
        while (pending_units.size() - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                push_str("\x1b[");
                if ($urandom_range(0, 3) == 0) push_str("?");
                np = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(0, 4);
                for (int j = 0; j < np; j++) begin
                    case ($urandom_range(0, 9))
                        0: ;
                        1: push_num($urandom_range(0, 99999));
                        2: push_num($urandom_range(1000, 1100) == 1049 ? 1049 : 47);
                        3: push_num($urandom_range(0, 65535));
                        4: push_str("?");
                        5: push_str(" ");
                        default: push_num($urandom_range(0, 110));
                    endcase
                    if (j < np - 1) push_str(";");
                end
                if ($urandom_range(0, 15) == 0)
                    pending_units.push_back(16'($urandom_range(0, 65535)));
                pending_units.push_back(16'(finals[$urandom_range(0, finals.len() - 1)]));
            end else if (pick < 60) begin
                push_str("\x1b");
                pending_units.push_back(16'($urandom_range(16'h20, 16'h7E)));
            end else if (pick < 66) begin
                case ($urandom_range(0, 2))
                    0: push_str("\x1b]0;t");
                    1: push_str("\x1bPq");
                    default: push_str("\x1b_x");
                endcase
                pending_units.push_back(16'($urandom_range(0, 65535)));
                pending_units.push_back($urandom_range(0, 1) ? CH_ESC : ($urandom_range(0, 1) ? CH_BEL : CH_ST));
            end else if (pick < 74) begin
                pending_units.push_back(16'($urandom_range(0, 31)));
            end else if (pick < 90) begin
                pending_units.push_back(16'($urandom_range(16'h20, 16'h7E)));
            end else begin
                pending_units.push_back(16'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial begin
        aclk = 0;
        aresetn = 0;
        s_valid = 0;
        s_code_unit = '0;
        m_ready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        units_sent = 0;
        cfg_default = 16'd0;
        cfg_rows = 8'd24;
        cfg_gfx = 1'b0;
        pr_mode = PM_NORMAL;
        pr_fg = 0;
        pr_bg = 0;
        pr_attrs = 0;
        clear_seq();
        foreach (pr_params[i]) pr_params[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, controls, ESC actions, special cases
        push_str("A~");
        pending_units.push_back(16'hFFFF);
        pending_units.push_back(16'h0020);
        for (int c = 0; c < 32; c++) if (c != 27) pending_units.push_back(16'(c));
        push_str("\x1bc\x1b=\x1b>\x1b7\x1b8\x1bH\x1bD\x1bE\x1bM\x1bz");
        push_str("\x1b[;H\x1b[99999A\x1b[0B\x1b[?1049;47h\x1b[3?4l\x1b[r");
        push_str("\x1b[1;31;42;97;107m\x1b[m\x1b[2J\x1b[1K\x1b[6n\x1b[5n");
        push_str("\x1b[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18h");
        push_str("\x1b[12 m\x1b[1");
        pending_units.push_back(16'h0661);
        push_str("x\x1b]2;ttl\x07\x1bPab\x1b\x1b^z");
        pending_units.push_back(CH_ST);
        push_str("\x1b[?h\x1b[?;?2l");
        run_and_drain();

        apb_write(REG_DEFAULT, 32'd65535);
        apb_write(REG_ROWS, 32'd0);
        apb_write(REG_GFX, 32'd1);
        push_str("_`~qx\x1b[;r\x1b[r\x1b[;m\x1b[99999;?H");
        add_random_units(4);
        run_and_drain();

        apb_write(REG_DEFAULT, 32'd1);
        apb_write(REG_ROWS, 32'd255);
        apb_write(REG_GFX, 32'd0);
        add_random_units(4);
        run_and_drain();

        apb_write(REG_DEFAULT, 32'($urandom_range(0, 65535)));
        apb_write(REG_ROWS, 32'd1);
        apb_write(REG_GFX, 32'd1);
        add_random_units(4);
        run_and_drain();

        apb_write(REG_DEFAULT, 32'd0);
        apb_write(REG_ROWS, 32'($urandom_range(1, 255)));
        apb_write(REG_GFX, 32'd0);
        add_random_units(4);
        run_and_drain();

        if (mismatches == 0 && expected_cmds.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
src/vtp_pkg.sv
src/vtp_cfg_regs.sv
src/vt100_escape_sequence_parser_top.sv
tb/sv/vt100_escape_sequence_parser_top_tb.sv
